// ----- design/gms_pkg.sv -----
package gms_pkg;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 64;
    localparam int EXP_W     = 11;
    localparam int PASS_W    = 5;
    localparam int ST_W      = 2;
    localparam int CFG_W     = 11;
    localparam int CFGI_W    = 2;
    localparam int LOG_EXP_W = 12;
    localparam int EXP_CLAMP = 512;
    localparam int CFG_RESET = 1024;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [ST_W-1:0]  t_status;
    typedef logic [CFGI_W-1:0] t_reg_index;

    localparam t_cmd CMD_LOAD = 2'd0;
    localparam t_cmd CMD_ROW  = 2'd1;
    localparam t_cmd CMD_COL  = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_VALUE = 2'd1;
    localparam t_status ST_INDEX     = 2'd2;
    localparam t_status ST_NOT_READY = 2'd3;

    localparam t_reg_index REG_ROW_COUNT = 2'd0;
    localparam t_reg_index REG_COL_COUNT = 2'd1;

endpackage

// ----- design/gms_if.sv -----
interface gms_in_if;
    import gms_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [VAL_W-1:0] value_bits;
    logic             last_entry;
    modport source (output valid, cmd, row_index, col_index, value_bits, last_entry,
                    input ready);
    modport sink (input valid, cmd, row_index, col_index, value_bits, last_entry,
                  output ready);
endinterface

interface gms_out_if;
    import gms_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [EXP_W-1:0] scale_exponent;
    logic                    clamped_any;
    logic [PASS_W-1:0]       passes_run;
    logic [ST_W-1:0]         status;
    modport source (output valid, scale_exponent, clamped_any, passes_run, status,
                    input ready);
    modport sink (input valid, scale_exponent, clamped_any, passes_run, status,
                  output ready);
endinterface

interface gms_cfg_if;
    import gms_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFGI_W-1:0] index;
    logic [CFG_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/gms_log2.sv -----
module gms_log2 #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic [gms_pkg::VAL_W-1:0]                   i_bits,
    output logic                                        o_done,
    output logic signed [FRAC_BITS+gms_pkg::LOG_EXP_W-1:0] o_log
);
    import gms_pkg::*;

    localparam int N_W = $clog2(FRAC_BITS);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQ   = 3'b100
    } t_lstate;

    t_lstate                       r_state;
    logic                          r_done;
    logic [52:0]                   r_man;
    logic signed [LOG_EXP_W-1:0]   r_e;
    logic [31:0]                   r_y;
    logic [FRAC_BITS-1:0]          r_f;
    logic [N_W-1:0]                r_n;
    logic [63:0]                   prod;
    logic [32:0]                   sq;
    logic [10:0]                   ef;

    assign ef   = i_bits[62:52];
    assign prod = r_y * r_y;
    assign sq   = prod[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= (ef == '0) ? L_NORM : L_SQ;
                    end
                end
                L_NORM: begin
                    if (r_man[52]) begin
                        r_state <= L_SQ;
                    end
                end
                L_SQ: begin
                    if (r_n == N_W'(FRAC_BITS - 1)) begin
                        r_state <= L_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_n <= '0;
                r_f <= '0;
                if (ef == '0) begin
                    r_man <= {1'b0, i_bits[51:0]};
                    r_e   <= -LOG_EXP_W'(1022);
                end else begin
                    r_man <= {1'b1, i_bits[51:0]};
                    r_e   <= $signed({1'b0, ef}) - LOG_EXP_W'(1023);
                end
                r_y <= {1'b1, i_bits[51:21]};
            end
            L_NORM: begin
                // shift a subnormal mantissa up one place per cycle
                if (r_man[52]) begin
                    r_y <= r_man[52:21];
                end else begin
                    r_man <= {r_man[51:0], 1'b0};
                    r_e   <= r_e - LOG_EXP_W'(1);
                end
            end
            L_SQ: begin
                r_n <= r_n + N_W'(1);
                if (sq[32]) begin
                    r_f <= {r_f[FRAC_BITS-2:0], 1'b1};
                    r_y <= sq[32:1];
                end else begin
                    r_f <= {r_f[FRAC_BITS-2:0], 1'b0};
                    r_y <= sq[31:0];
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_log  = {r_e, r_f};

endmodule

// ----- design/geometric_matrix_scaling.sv -----
// Load: a valid value goes through the log2 unit (a subnormal mantissa is first normalized
// one mantissa bit per cycle, then squared once per fraction bit). One item at a time.
// A last entry adds a clear sweep over max(MAX_ROWS, MAX_COLS) addresses, then per pass
// a row scan of the entries, a row offset update and a column walk over the state memories,
// and a final sweep over max(rows, cols) for the clamp check.
// Reset (synchronous, active low) empties the store and drops computed scales.
module geometric_matrix_scaling #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ENTRIES = 4096,
    parameter int MAX_PASSES  = 20,
    parameter int FRAC_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gms_in_if.sink    i_in,
    gms_out_if.source o_out,
    gms_cfg_if.sink   i_cfg
);
    import gms_pkg::*;

    localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CA_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EA_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EC_W  = $clog2(MAX_ENTRIES + 1);
    localparam int RN_W  = $clog2(MAX_ROWS + 1);
    localparam int CN_W  = $clog2(MAX_COLS + 1);
    localparam int SW_W  = (RN_W > CN_W) ? RN_W : CN_W;
    localparam int PC_W  = $clog2(MAX_PASSES + 1);
    localparam int LOG_W = FRAC_BITS + LOG_EXP_W;
    localparam int OFF_W = LOG_W + 4;
    localparam int V_W   = OFF_W + 2;
    localparam int S_W   = V_W + 1;
    localparam int EW    = 2 * IDX_W + LOG_W;
    localparam int MW    = 2 * V_W + 1;
    localparam int RR_W  = OFF_W + 1 - FRAC_BITS;
    localparam int CLR_N = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int TOL_FIX = ((1 << FRAC_BITS) + 500) / 1000;
    localparam longint HALF_FIX = longint'(1) << (FRAC_BITS - 1);
    localparam longint CL_THR = longint'(2 * EXP_CLAMP + 1) << (FRAC_BITS - 1);
    localparam int NR_RST = (CFG_RESET > MAX_ROWS) ? MAX_ROWS : CFG_RESET;
    localparam int NC_RST = (CFG_RESET > MAX_COLS) ? MAX_COLS : CFG_RESET;

    typedef enum logic [18:0] {
        S_IDLE = 19'b0000000000000000001,
        S_LOG  = 19'b0000000000000000010,
        S_CLR  = 19'b0000000000000000100,
        S_RA   = 19'b0000000000000001000,
        S_RB   = 19'b0000000000000010000,
        S_RC   = 19'b0000000000000100000,
        S_RD   = 19'b0000000000001000000,
        S_UA   = 19'b0000000000010000000,
        S_UB   = 19'b0000000000100000000,
        S_CA   = 19'b0000000001000000000,
        S_CB   = 19'b0000000010000000000,
        S_CC   = 19'b0000000100000000000,
        S_CD   = 19'b0000001000000000000,
        S_CF   = 19'b0000010000000000000,
        S_FA   = 19'b0000100000000000000,
        S_FB   = 19'b0001000000000000000,
        S_QB   = 19'b0010000000000000000,
        S_OUT  = 19'b0100000000000000000,
        S_SPARE = 19'b1000000000000000000
    } t_state;

    // memories
    logic [EW-1:0]           r_ent_mem [MAX_ENTRIES];
    logic [OFF_W-1:0]        r_ro_mem  [MAX_ROWS];
    logic [OFF_W-1:0]        r_co_mem  [MAX_COLS];
    logic [MW-1:0]           r_mm_mem  [MAX_ROWS];
    logic [EW-1:0]           r_ent_q;
    logic signed [OFF_W-1:0] r_ro_q;
    logic signed [OFF_W-1:0] r_co_q;
    logic [MW-1:0]           r_mm_q;

    logic            ent_we, ent_re, ro_we, ro_re, co_we, co_re, mm_we, mm_re;
    logic [EA_W-1:0] ent_wa, ent_ra;
    logic [EW-1:0]   ent_wd;
    logic [RA_W-1:0] ro_wa, ro_ra, mm_wa, mm_ra;
    logic [CA_W-1:0] co_wa, co_ra;
    logic [OFF_W-1:0] ro_wd, co_wd;
    logic [MW-1:0]   mm_wd;

    // control and payload registers
    t_state                  r_state, n_state;
    logic [EC_W-1:0]         r_cnt, n_cnt, r_k, n_k;
    logic [SW_W-1:0]         r_i, n_i;
    t_status                 r_err, n_err, r_st, n_st;
    logic                    r_clamp, n_clamp, r_ready, n_ready;
    logic [PC_W-1:0]         r_pass, n_pass;
    logic [IDX_W-1:0]        r_last_col, n_last_col;
    logic [RN_W-1:0]         r_nr;
    logic [CN_W-1:0]         r_nc;
    logic signed [EXP_W-1:0] r_ex, n_ex;
    logic                    r_is_last, n_is_last, r_sel, n_sel;
    logic [IDX_W-1:0]        r_e_row, n_e_row, r_e_col, n_e_col, r_cc, n_cc;
    logic signed [LOG_W-1:0] r_e_log, n_e_log;
    logic signed [V_W-1:0]   r_v, n_v, r_cmin, n_cmin, r_cmax, n_cmax;
    logic                    r_ok, n_ok, r_any, n_any, r_grp, n_grp;
    logic signed [OFF_W-1:0] r_coff, n_coff;
    logic signed [S_W-1:0]   r_spread, n_spread, r_prev, n_prev;
    logic                    r_prev_ok, n_prev_ok, r_clacc, n_clacc;

    logic                    r_ov;
    logic signed [EXP_W-1:0] r_o_ex;
    logic                    r_o_cl;
    logic [PASS_W-1:0]       r_o_pass;
    t_status                 r_o_st;

    // derived
    logic                    in_acc, out_load, log_done, log_start;
    logic signed [LOG_W-1:0] log_res;
    logic [IDX_W-1:0]        q_row, q_col;
    logic signed [LOG_W-1:0] q_log;
    logic                    mm_seen;
    logic signed [V_W-1:0]   mm_min, mm_max;
    logic signed [S_W-1:0]   u_sum, u_hf, u_diff, c_sum, c_hf;
    logic signed [S_W:0]     p_diff;
    logic [SW_W-1:0]         imax;
    logic                    row_bad, col_bad;
    logic [EC_W-1:0]         ld_cnt;
    t_status                 ld_err, ld_st;
    logic signed [OFF_W-1:0] rd_q;
    logic [OFF_W-1:0]        rd_mag, ro_mag, co_mag;
    logic [OFF_W:0]          rd_sum;
    logic [RR_W-1:0]         rd_r;
    logic [EXP_W-1:0]        rd_lim;
    logic                    fin_hit, pass_done;
    int                      cfg_v;

    gms_log2 #(.FRAC_BITS(FRAC_BITS)) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_bits  (i_in.value_bits),
        .o_done  (log_done),
        .o_log   (log_res)
    );

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_OUT) && (!r_ov || o_out.ready);
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign q_row   = r_ent_q[EW-1 -: IDX_W];
    assign q_col   = r_ent_q[LOG_W +: IDX_W];
    assign q_log   = r_ent_q[LOG_W-1:0];
    assign mm_seen = r_mm_q[MW-1];
    assign mm_min  = r_mm_q[2*V_W-1:V_W];
    assign mm_max  = r_mm_q[V_W-1:0];
    assign u_sum   = S_W'(mm_min) + S_W'(mm_max);
    assign u_hf    = u_sum >>> 1;
    assign u_diff  = S_W'(mm_max) - S_W'(mm_min);
    assign c_sum   = S_W'(r_cmin) + S_W'(r_cmax);
    assign c_hf    = c_sum >>> 1;
    assign p_diff  = (S_W+1)'(r_prev) - (S_W+1)'(r_spread);
    assign imax    = (32'(r_nr) > 32'(r_nc)) ? SW_W'(r_nr) : SW_W'(r_nc);
    assign row_bad = 32'(i_in.row_index) >= 32'(r_nr);
    assign col_bad = 32'(i_in.col_index) >= 32'(r_nc);

    assign ro_mag  = r_ro_q[OFF_W-1] ? OFF_W'(-r_ro_q) : OFF_W'(r_ro_q);
    assign co_mag  = r_co_q[OFF_W-1] ? OFF_W'(-r_co_q) : OFF_W'(r_co_q);
    assign fin_hit = ((32'(r_i) < 32'(r_nr)) && (ro_mag >= OFF_W'(CL_THR)))
                  || ((32'(r_i) < 32'(r_nc)) && (co_mag >= OFF_W'(CL_THR)));
    assign pass_done = (r_spread <= S_W'(0))
                    || (r_prev_ok && (p_diff < (S_W+1)'(TOL_FIX)))
                    || (r_pass == PC_W'(MAX_PASSES));

    // round half away from zero, then clamp
    always_comb begin
        rd_q   = r_sel ? r_co_q : r_ro_q;
        rd_mag = rd_q[OFF_W-1] ? OFF_W'(-rd_q) : OFF_W'(rd_q);
        rd_sum = (OFF_W+1)'(rd_mag) + (OFF_W+1)'(HALF_FIX);
        rd_r   = rd_sum[OFF_W:FRAC_BITS];
        rd_lim = (32'(rd_r) > EXP_CLAMP) ? EXP_W'(EXP_CLAMP) : EXP_W'(rd_r);
    end

    // load checks; a load after computed scales starts a new matrix
    always_comb begin
        ld_cnt = r_ready ? '0 : r_cnt;
        ld_err = r_ready ? ST_OK : r_err;
        if (i_in.value_bits[62:52] == '1 || i_in.value_bits[62:0] == '0) begin
            ld_st = ST_BAD_VALUE;
        end else if (row_bad || col_bad) begin
            ld_st = ST_INDEX;
        end else if (ld_cnt == EC_W'(MAX_ENTRIES)) begin
            ld_st = ST_INDEX;
        end else if (ld_cnt != '0 && i_in.col_index < r_last_col) begin
            ld_st = ST_INDEX;
        end else begin
            ld_st = ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;   n_cnt = r_cnt;       n_k = r_k;         n_i = r_i;
        n_err = r_err;       n_st = r_st;         n_clamp = r_clamp; n_ready = r_ready;
        n_pass = r_pass;     n_last_col = r_last_col;                n_ex = r_ex;
        n_is_last = r_is_last;                    n_sel = r_sel;
        n_e_row = r_e_row;   n_e_col = r_e_col;   n_e_log = r_e_log; n_cc = r_cc;
        n_v = r_v;           n_ok = r_ok;         n_cmin = r_cmin;   n_cmax = r_cmax;
        n_any = r_any;       n_grp = r_grp;       n_coff = r_coff;
        n_spread = r_spread; n_prev = r_prev;     n_prev_ok = r_prev_ok;
        n_clacc = r_clacc;
        log_start = 1'b0;
        ent_we = 1'b0; ent_re = 1'b0; ent_wa = r_cnt[EA_W-1:0]; ent_ra = r_k[EA_W-1:0];
        ent_wd = {r_e_row, r_e_col, log_res};
        ro_we = 1'b0; ro_re = 1'b0; ro_wa = RA_W'(r_i); ro_ra = RA_W'(r_i); ro_wd = '0;
        co_we = 1'b0; co_re = 1'b0; co_wa = CA_W'(r_i); co_ra = CA_W'(r_i); co_wd = '0;
        mm_we = 1'b0; mm_re = 1'b0; mm_wa = RA_W'(r_i); mm_ra = RA_W'(r_i); mm_wd = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ex = '0;
                    case (i_in.cmd)
                        CMD_LOAD: begin
                            if (r_ready) begin
                                n_cnt   = '0;
                                n_clamp = 1'b0;
                                n_ready = 1'b0;
                                n_pass  = '0;
                            end
                            n_st      = ld_st;
                            n_err     = (ld_st > ld_err) ? ld_st : ld_err;
                            n_is_last = i_in.last_entry;
                            n_e_row   = i_in.row_index;
                            n_e_col   = i_in.col_index;
                            if (ld_st == ST_OK) begin
                                log_start = 1'b1;
                                n_state   = S_LOG;
                            end else if (i_in.last_entry) begin
                                n_i     = '0;
                                n_pass  = '0;
                                n_state = S_CLR;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        CMD_ROW, CMD_COL: begin
                            n_sel = (i_in.cmd == CMD_COL);
                            if (!r_ready) begin
                                n_st    = ST_NOT_READY;
                                n_state = S_OUT;
                            end else if ((i_in.cmd == CMD_ROW && row_bad)
                                    || (i_in.cmd == CMD_COL && col_bad)) begin
                                n_st    = ST_INDEX;
                                n_state = S_OUT;
                            end else begin
                                ro_re   = (i_in.cmd == CMD_ROW);
                                co_re   = (i_in.cmd == CMD_COL);
                                ro_ra   = RA_W'(i_in.row_index);
                                co_ra   = CA_W'(i_in.col_index);
                                n_state = S_QB;
                            end
                        end
                        default: begin
                            n_st    = ST_INDEX;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_LOG: begin
                if (log_done) begin
                    ent_we     = 1'b1;
                    n_cnt      = r_cnt + EC_W'(1);
                    n_last_col = r_e_col;
                    if (r_is_last) begin
                        n_i     = '0;
                        n_pass  = '0;
                        n_state = S_CLR;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            // clear the full depth so rows and columns added later read as zero
            S_CLR: begin
                ro_we = (32'(r_i) < MAX_ROWS);
                mm_we = ro_we;
                co_we = (32'(r_i) < MAX_COLS);
                if (32'(r_i) + 32'd1 >= CLR_N) begin
                    n_pass    = PC_W'(1);
                    n_prev_ok = 1'b0;
                    n_spread  = '0;
                    n_k       = '0;
                    n_i       = '0;
                    n_state   = (r_cnt == '0) ? S_UA : S_RA;
                end else begin
                    n_i = r_i + SW_W'(1);
                end
            end
            // row scan: min and max of v per row
            S_RA: begin
                ent_re  = 1'b1;
                n_state = S_RB;
            end
            S_RB: begin
                n_e_row = q_row;
                n_e_col = q_col;
                n_e_log = q_log;
                ro_re   = 1'b1;
                co_re   = 1'b1;
                mm_re   = 1'b1;
                ro_ra   = RA_W'(q_row);
                co_ra   = CA_W'(q_col);
                mm_ra   = RA_W'(q_row);
                n_state = S_RC;
            end
            S_RC: begin
                n_v = V_W'(r_e_log) + V_W'(r_ro_q) + V_W'(r_co_q);
                n_ok = (32'(r_e_row) < 32'(r_nr)) && (32'(r_e_col) < 32'(r_nc));
                n_state = S_RD;
            end
            S_RD: begin
                if (r_ok) begin
                    mm_we = 1'b1;
                    mm_wa = RA_W'(r_e_row);
                    mm_wd = {1'b1,
                             (!mm_seen || r_v < mm_min) ? r_v : mm_min,
                             (!mm_seen || r_v > mm_max) ? r_v : mm_max};
                end
                n_k = r_k + EC_W'(1);
                if (r_k + EC_W'(1) == r_cnt) begin
                    n_i     = '0;
                    n_state = S_UA;
                end else begin
                    n_state = S_RA;
                end
            end
            // row offsets, spread, and clear seen for the next pass
            S_UA: begin
                ro_re   = 1'b1;
                mm_re   = 1'b1;
                n_state = S_UB;
            end
            S_UB: begin
                if (mm_seen) begin
                    ro_we = 1'b1;
                    ro_wd = OFF_W'(S_W'(r_ro_q) - u_hf);
                    mm_we = 1'b1;
                    if (u_diff > r_spread) begin
                        n_spread = u_diff;
                    end
                end
                if (32'(r_i) + 32'd1 == 32'(r_nr)) begin
                    n_k     = '0;
                    n_grp   = 1'b0;
                    n_any   = 1'b0;
                    n_state = (r_cnt == '0) ? S_CF : S_CA;
                end else begin
                    n_i     = r_i + SW_W'(1);
                    n_state = S_UA;
                end
            end
            // column walk: entries arrive grouped by column
            S_CA: begin
                ent_re  = 1'b1;
                n_state = S_CB;
            end
            S_CB: begin
                n_e_row = q_row;
                n_e_col = q_col;
                n_e_log = q_log;
                if (r_grp && q_col != r_cc && r_any) begin
                    co_we = 1'b1;
                    co_wa = CA_W'(r_cc);
                    co_wd = OFF_W'(S_W'(r_coff) - c_hf);
                end
                if (!r_grp || q_col != r_cc) begin
                    n_any = 1'b0;
                end
                n_grp   = 1'b1;
                n_cc    = q_col;
                ro_re   = 1'b1;
                co_re   = 1'b1;
                ro_ra   = RA_W'(q_row);
                co_ra   = CA_W'(q_col);
                n_state = S_CC;
            end
            S_CC: begin
                n_v = V_W'(r_e_log) + V_W'(r_ro_q) + V_W'(r_co_q);
                n_ok = (32'(r_e_row) < 32'(r_nr)) && (32'(r_e_col) < 32'(r_nc));
                n_coff  = r_co_q;
                n_state = S_CD;
            end
            S_CD: begin
                if (r_ok) begin
                    n_cmin = (!r_any || r_v < r_cmin) ? r_v : r_cmin;
                    n_cmax = (!r_any || r_v > r_cmax) ? r_v : r_cmax;
                    n_any  = 1'b1;
                end
                n_k     = r_k + EC_W'(1);
                n_state = (r_k + EC_W'(1) == r_cnt) ? S_CF : S_CA;
            end
            S_CF: begin
                if (r_grp && r_any) begin
                    co_we = 1'b1;
                    co_wa = CA_W'(r_cc);
                    co_wd = OFF_W'(S_W'(r_coff) - c_hf);
                end
                if (pass_done) begin
                    n_i     = '0;
                    n_clacc = 1'b0;
                    n_state = S_FA;
                end else begin
                    n_prev    = r_spread;
                    n_prev_ok = 1'b1;
                    n_pass    = r_pass + PC_W'(1);
                    n_spread  = '0;
                    n_k       = '0;
                    n_i       = '0;
                    n_state   = (r_cnt == '0) ? S_UA : S_RA;
                end
            end
            // clamp check over all row and column offsets in use
            S_FA: begin
                ro_re   = 1'b1;
                co_re   = 1'b1;
                n_state = S_FB;
            end
            S_FB: begin
                n_clacc = r_clacc | fin_hit;
                if (32'(r_i) + 32'd1 >= 32'(imax)) begin
                    n_clamp = r_clacc | fin_hit;
                    n_ready = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_i     = r_i + SW_W'(1);
                    n_state = S_FA;
                end
            end
            S_QB: begin
                n_ex    = rd_q[OFF_W-1] ? -$signed(rd_lim) : $signed(rd_lim);
                n_st    = r_err;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_err   <= ST_OK;
            r_clamp <= 1'b0;
            r_ready <= 1'b0;
            r_pass  <= '0;
            r_nr    <= RN_W'(NR_RST);
            r_nc    <= CN_W'(NC_RST);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_clamp <= n_clamp;
            r_ready <= n_ready;
            r_pass  <= n_pass;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ROW_COUNT: r_nr <= (cfg_v == 0) ? RN_W'(1)
                        : (cfg_v > MAX_ROWS) ? RN_W'(MAX_ROWS) : RN_W'(cfg_v);
                    REG_COL_COUNT: r_nc <= (cfg_v == 0) ? CN_W'(1)
                        : (cfg_v > MAX_COLS) ? CN_W'(MAX_COLS) : CN_W'(cfg_v);
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign cfg_v = int'(i_cfg.data);

    always_ff @(posedge i_clk) begin
        r_k <= n_k;           r_i <= n_i;             r_st <= n_st;
        r_last_col <= n_last_col;                     r_ex <= n_ex;
        r_is_last <= n_is_last;                       r_sel <= n_sel;
        r_e_row <= n_e_row;   r_e_col <= n_e_col;     r_e_log <= n_e_log;
        r_cc <= n_cc;         r_v <= n_v;             r_ok <= n_ok;
        r_cmin <= n_cmin;     r_cmax <= n_cmax;       r_any <= n_any;
        r_grp <= n_grp;       r_coff <= n_coff;       r_spread <= n_spread;
        r_prev <= n_prev;     r_prev_ok <= n_prev_ok; r_clacc <= n_clacc;
        if (out_load) begin
            r_o_ex   <= r_ex;
            r_o_cl   <= r_clamp;
            r_o_pass <= PASS_W'(r_pass);
            r_o_st   <= r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_re) begin
            r_ent_q <= r_ent_mem[ent_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ro_we) begin
            r_ro_mem[ro_wa] <= ro_wd;
        end
        if (ro_re) begin
            r_ro_q <= r_ro_mem[ro_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (co_we) begin
            r_co_mem[co_wa] <= co_wd;
        end
        if (co_re) begin
            r_co_q <= r_co_mem[co_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mm_we) begin
            r_mm_mem[mm_wa] <= mm_wd;
        end
        if (mm_re) begin
            r_mm_q <= r_mm_mem[mm_ra];
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.scale_exponent = r_o_ex;
    assign o_out.clamped_any    = r_o_cl;
    assign o_out.passes_run     = r_o_pass;
    assign o_out.status         = r_o_st;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_ENTRIES)
        else $error("entry count beyond store depth");
    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pass) <= MAX_PASSES)
        else $error("pass count beyond limit");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_OUT))
        else $error("result word raised outside output state");
    a_pass_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RA || r_state == S_UA || r_state == S_CA) |-> !r_ready)
        else $error("scales marked ready during passes");
`endif

endmodule

// ----- test/geometric_matrix_scaling_tb.sv -----
module geometric_matrix_scaling_tb;
    import gms_pkg::*;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLS    = 1024;
    localparam int MAX_ENTRIES = 4096;
    localparam int MAX_PASSES  = 20;
    localparam int FRAC_BITS   = 16;
    localparam longint ONE_FIX = longint'(1) << FRAC_BITS;
    localparam longint TOL_FIX = (ONE_FIX + 500) / 1000;
    localparam t_cmd CMD_NONE  = 2'd3;

    localparam logic [63:0] D_ONE     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] D_MAXFIN  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] D_MINSUB  = 64'h0000_0000_0000_0001;
    localparam logic [63:0] D_NEG2P5  = 64'hC004_0000_0000_0000;
    localparam logic [63:0] D_INF     = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] D_NAN     = 64'hFFF8_0000_0000_0001;
    localparam logic [63:0] D_NEGZERO = 64'h8000_0000_0000_0000;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_word;

    typedef struct packed {
        logic signed [EXP_W-1:0] exponent;
        logic                    clamped;
        logic [PASS_W-1:0]       passes;
        t_status                 status;
    } t_scale;

    typedef struct packed {
        t_word  w;
        logic   typed;
        t_scale res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #4 i_clk = ~i_clk;

    gms_in_if  in_if();
    gms_out_if out_if();
    gms_cfg_if cfg_if();

    geometric_matrix_scaling u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // predictor state
    logic [IDX_W-1:0] st_row [MAX_ENTRIES];
    logic [IDX_W-1:0] st_col [MAX_ENTRIES];
    longint           st_log [MAX_ENTRIES];
    longint           row_off [MAX_ROWS];
    longint           col_off [MAX_COLS];
    longint           rmin [MAX_ROWS];
    longint           rmax [MAX_ROWS];
    bit               rseen [MAX_ROWS];
    int               n_stored, err_flag, clamp_flag, ready_flag, pass_cnt;
    int               cfg_rows = CFG_RESET, cfg_cols = CFG_RESET;

    t_scale expected_scales[$];
    bit     failed = 1'b0;
    bit     idle_on = 1'b1;
    int     n_sent, n_loads, n_reads, n_computes, n_checked;

    function automatic int clip(int v, int lim);
        if (v < 1) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic longint half_floor(longint s);
        if (s >= 0) return s / 2;
        return -((-s + 1) / 2);
    endfunction

    function automatic longint log2_fixed(logic [63:0] bits);
        int               ef;
        longint unsigned  man, y;
        longint           e, f;
        ef  = int'(bits[62:52]);
        man = {12'd0, bits[51:0]};
        f   = 0;
        if (ef == 0) begin
            e = -1022;
            while (man != 0 && man[52] == 1'b0) begin
                man = man << 1;
                e--;
            end
        end else begin
            e = ef - 1023;
            man[52] = 1'b1;
        end
        y = man >> 21;
        for (int i = 0; i < FRAC_BITS; i++) begin
            y = (y * y) >> 31;
            f = f * 2;
            if (y >= 64'h1_0000_0000) begin
                f += 1;
                y = y >> 1;
            end
        end
        return e * ONE_FIX + f;
    endfunction

    function automatic longint round_exponent(longint off, inout bit clamped);
        longint mag, r;
        mag = off < 0 ? -off : off;
        r = (mag + ONE_FIX / 2) / ONE_FIX;
        if (r > EXP_CLAMP) begin
            r = EXP_CLAMP;
            clamped = 1'b1;
        end
        return off < 0 ? -r : r;
    endfunction

    function automatic void clear_matrix();
        n_stored = 0;
        for (int i = 0; i < MAX_ROWS; i++) row_off[i] = 0;
        for (int i = 0; i < MAX_COLS; i++) col_off[i] = 0;
        err_flag = 0;
        clamp_flag = 0;
        ready_flag = 0;
        pass_cnt = 0;
    endfunction

    function automatic void balance_matrix();
        int     nr, nc, k, r, c;
        longint prev, spread, v, cmin, cmax;
        bit     prev_ok, cl, any;
        longint dummy;
        nr = clip(cfg_rows, MAX_ROWS);
        nc = clip(cfg_cols, MAX_COLS);
        prev = 0;
        prev_ok = 0;
        cl = 0;
        for (int i = 0; i < MAX_ROWS; i++) row_off[i] = 0;
        for (int i = 0; i < MAX_COLS; i++) col_off[i] = 0;
        pass_cnt = 0;
        for (int p = 0; p < MAX_PASSES; p++) begin
            spread = 0;
            pass_cnt = p + 1;
            for (r = 0; r < nr; r++) rseen[r] = 0;
            for (k = 0; k < n_stored; k++) begin
                r = st_row[k];
                c = st_col[k];
                if (r < nr && c < nc) begin
                    v = st_log[k] + row_off[r] + col_off[c];
                    if (!rseen[r] || v < rmin[r]) rmin[r] = v;
                    if (!rseen[r] || v > rmax[r]) rmax[r] = v;
                    rseen[r] = 1;
                end
            end
            for (r = 0; r < nr; r++) begin
                if (rseen[r]) begin
                    if (rmax[r] - rmin[r] > spread) spread = rmax[r] - rmin[r];
                    row_off[r] -= half_floor(rmin[r] + rmax[r]);
                end
            end
            k = 0;
            while (k < n_stored) begin
                c = st_col[k];
                any = 0;
                cmin = 0;
                cmax = 0;
                while (k < n_stored && st_col[k] == c) begin
                    r = st_row[k];
                    if (r < nr && c < nc) begin
                        v = st_log[k] + row_off[r] + col_off[c];
                        if (!any || v < cmin) cmin = v;
                        if (!any || v > cmax) cmax = v;
                        any = 1;
                    end
                    k++;
                end
                if (any) col_off[c] -= half_floor(cmin + cmax);
            end
            if (spread <= 0 || (prev_ok && prev - spread < TOL_FIX)) break;
            prev = spread;
            prev_ok = 1;
        end
        for (r = 0; r < nr; r++) dummy = round_exponent(row_off[r], cl);
        for (c = 0; c < nc; c++) dummy = round_exponent(col_off[c], cl);
        clamp_flag = cl;
        ready_flag = 1;
    endfunction

    function automatic t_scale predict_scale(t_word w);
        t_scale s;
        int     nr, nc, st;
        longint ex;
        bit     dummy;
        nr = clip(cfg_rows, MAX_ROWS);
        nc = clip(cfg_cols, MAX_COLS);
        ex = 0;
        st = ST_OK;
        dummy = 0;
        if (w.cmd == CMD_LOAD) begin
            if (ready_flag) clear_matrix();
            if (w.value[62:52] == 11'h7FF || w.value[62:0] == 63'd0)
                st = ST_BAD_VALUE;
            else if (w.row >= nr || w.col >= nc)
                st = ST_INDEX;
            else if (n_stored >= MAX_ENTRIES)
                st = ST_INDEX;
            else if (n_stored > 0 && w.col < st_col[n_stored-1])
                st = ST_INDEX;
            else begin
                st_row[n_stored] = w.row;
                st_col[n_stored] = w.col;
                st_log[n_stored] = log2_fixed(w.value);
                n_stored++;
            end
            if (st > err_flag) err_flag = st;
            if (w.last) begin
                balance_matrix();
                n_computes++;
            end
        end else if (w.cmd == CMD_ROW || w.cmd == CMD_COL) begin
            if (!ready_flag)
                st = ST_NOT_READY;
            else if ((w.cmd == CMD_ROW && w.row >= nr) || (w.cmd == CMD_COL && w.col >= nc))
                st = ST_INDEX;
            else begin
                ex = round_exponent(w.cmd == CMD_ROW ? row_off[w.row] : col_off[w.col], dummy);
                st = err_flag;
            end
        end else begin
            st = ST_INDEX;
        end
        s.exponent = ex[EXP_W-1:0];
        s.clamped  = clamp_flag[0];
        s.passes   = pass_cnt[PASS_W-1:0];
        s.status   = st[ST_W-1:0];
        return s;
    endfunction

    task automatic send_word(t_word w, bit typed = 0, t_scale res = '0);
        t_scale s;
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 12) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.cmd        <= w.cmd;
        in_if.row_index  <= w.row;
        in_if.col_index  <= w.col;
        in_if.value_bits <= w.value;
        in_if.last_entry <= w.last;
        do @(posedge i_clk); while (!in_if.ready);
        s = predict_scale(w);
        expected_scales.push_back(typed ? res : s);
        n_sent++;
        if (w.cmd == CMD_LOAD) n_loads++;
        else n_reads++;
    endtask

    // wait for every expected word, then a little settling time
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_scales.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [CFG_W-1:0] data);
        drain();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == REG_ROW_COUNT) cfg_rows = data;
        else cfg_cols = data;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    always @(negedge i_clk)
        out_if.ready <= !idle_on || $urandom_range(0, 99) >= 12;

    always @(posedge i_clk) begin
        t_scale e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_scales.size() == 0) begin
                $error("unexpected result word");
                failed = 1'b1;
            end else begin
                e = expected_scales.pop_front();
                n_checked++;
                if (out_if.scale_exponent !== e.exponent) begin
                    $error("scale_exponent: expected %0d, got %0d",
                           e.exponent, out_if.scale_exponent);
                    failed = 1'b1;
                end
                if (out_if.clamped_any !== e.clamped) begin
                    $error("clamped_any: expected %0d, got %0d", e.clamped, out_if.clamped_any);
                    failed = 1'b1;
                end
                if (out_if.passes_run !== e.passes) begin
                    $error("passes_run: expected %0d, got %0d", e.passes, out_if.passes_run);
                    failed = 1'b1;
                end
                if (out_if.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, out_if.status);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic logic [63:0] rand_value();
        int          pick;
        logic [63:0] v;
        pick = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (pick < 80) v[62:52] = 11'(1023 - 30 + $urandom_range(0, 60));
        else if (pick < 88) v[62:52] = 11'd0;
        else if (pick < 93) v[62:52] = $urandom_range(0, 1) ? 11'd1 : 11'd2046;
        if (v[62:0] == 63'd0) v[0] = 1'b1;
        return v;
    endfunction

    function automatic t_word mk(t_cmd cmd, int r, int c, logic [63:0] v, bit last);
        t_word w;
        w.cmd   = cmd;
        w.row   = r[IDX_W-1:0];
        w.col   = c[IDX_W-1:0];
        w.value = v;
        w.last  = last;
        return w;
    endfunction

    function automatic int rand_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return $urandom_range(1, 16);
        if (pick < 85) return 0;
        if (pick < 90) return 2047;
        if (pick < 95) return 1024;
        return $urandom_range(17, 200);
    endfunction

    // one matrix: well-formed loads with some noise, then reads
    task automatic random_matrix();
        int nr, nc, n, c, r;
        logic [63:0] v;
        t_word w;
        nr = clip(cfg_rows, MAX_ROWS);
        nc = clip(cfg_cols, MAX_COLS);
        n = $urandom_range(1, 10);
        c = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                send_word(mk(CMD_ROW, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             rand_value(), 1'($urandom_range(0, 1))));
            end
            if ($urandom_range(0, 99) < 4 && i > 0) begin
                // shrink the row count with entries already stored
                write_reg(REG_ROW_COUNT, CFG_W'($urandom_range(1, nr)));
                nr = clip(cfg_rows, MAX_ROWS);
            end
            c = c + $urandom_range(0, 2);
            if (c > nc - 1) c = nc - 1;
            r = $urandom_range(0, nr - 1);
            v = rand_value();
            case ($urandom_range(0, 99))
                0, 1, 2: v = $urandom_range(0, 1) ? D_INF : {1'($urandom_range(0, 1)), 63'd0};
                3, 4:    r = $urandom_range(0, 1023);
                5, 6:    c = $urandom_range(0, 1023);
                7:       v[62:52] = 11'h7FF;
                default: ;
            endcase
            send_word(mk(CMD_LOAD, r, c, v, i == n - 1));
            if (c > nc - 1) c = nc - 1;
        end
        n = $urandom_range(3, 10);
        for (int i = 0; i < n; i++) begin
            w = mk($urandom_range(0, 1) ? CMD_ROW : CMD_COL,
                   $urandom_range(0, nr - 1), $urandom_range(0, nc - 1), {$urandom, $urandom},
                   1'($urandom_range(0, 1)));
            if ($urandom_range(0, 99) < 10) begin
                w.row = IDX_W'($urandom_range(0, 1023));
                w.col = IDX_W'($urandom_range(0, 1023));
            end
            if ($urandom_range(0, 99) < 3) w.cmd = CMD_NONE;
            send_word(w);
        end
    endtask

    t_row plan[$];

    initial begin
        t_scale not_ready, bad_val, bad_cmd;
        in_if.valid = 1'b0;
        in_if.cmd = CMD_LOAD;
        in_if.row_index = '0;
        in_if.col_index = '0;
        in_if.value_bits = '0;
        in_if.last_entry = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_ROW_COUNT;
        cfg_if.data = '0;
        out_if.ready = 1'b0;
        clear_matrix();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        not_ready = '{exponent: '0, clamped: 1'b0, passes: '0, status: ST_NOT_READY};
        bad_val   = '{exponent: '0, clamped: 1'b0, passes: '0, status: ST_BAD_VALUE};
        bad_cmd   = '{exponent: '0, clamped: 1'b0, passes: '0, status: ST_INDEX};
        plan = '{
            '{mk(CMD_ROW, 0, 0, 0, 0), 1, not_ready},
            '{mk(CMD_COL, 1023, 1023, '1, 1), 1, not_ready},
            '{mk(CMD_NONE, 0, 0, 0, 0), 1, bad_cmd},
            '{mk(CMD_LOAD, 0, 0, 0, 0), 1, bad_val},
            '{mk(CMD_LOAD, 0, 0, D_INF, 0), 1, bad_val},
            '{mk(CMD_LOAD, 0, 0, D_NAN, 0), 1, bad_val},
            '{mk(CMD_LOAD, 0, 0, D_NEGZERO, 0), 1, bad_val},
            '{mk(CMD_LOAD, 1023, 0, D_ONE, 0), 0, '0},
            '{mk(CMD_LOAD, 5, 3, D_MAXFIN, 0), 0, '0},
            '{mk(CMD_LOAD, 0, 2, D_ONE, 0), 1, bad_cmd},
            '{mk(CMD_LOAD, 0, 3, D_MINSUB, 0), 0, '0},
            '{mk(CMD_LOAD, 2, 1023, D_NEG2P5, 1), 0, '0},
            '{mk(CMD_ROW, 1023, 0, 0, 0), 0, '0},
            '{mk(CMD_ROW, 5, 0, 0, 0), 0, '0},
            '{mk(CMD_ROW, 0, 0, 0, 0), 0, '0},
            '{mk(CMD_ROW, 900, 0, 0, 0), 0, '0},
            '{mk(CMD_COL, 0, 3, 0, 0), 0, '0},
            '{mk(CMD_COL, 0, 1023, 0, 0), 0, '0},
            '{mk(CMD_LOAD, 7, 8, 64'h4010_0000_0000_0000, 0), 0, '0},
            '{mk(CMD_LOAD, 9, 8, 64'h3FC0_0000_0000_0000, 1), 0, '0},
            '{mk(CMD_ROW, 7, 0, 0, 0), 0, '0},
            '{mk(CMD_COL, 0, 8, 0, 0), 0, '0}
        };
        foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].res);

        // smallest counts, back to back with no idling
        write_reg(REG_ROW_COUNT, 0);
        write_reg(REG_COL_COUNT, 1);
        idle_on = 1'b0;
        for (int i = 0; i < 6; i++)
            send_word(mk(CMD_LOAD, 0, 0, D_ONE, i == 5));
        send_word(mk(CMD_ROW, 0, 0, 0, 0));
        send_word(mk(CMD_ROW, 1, 0, 0, 0));
        idle_on = 1'b1;

        write_reg(REG_ROW_COUNT, 2047);
        write_reg(REG_COL_COUNT, 2047);
        random_matrix();
        while (n_sent < 650) begin
            if ($urandom_range(0, 99) < 40) begin
                write_reg(REG_ROW_COUNT, CFG_W'(rand_count()));
                write_reg(REG_COL_COUNT, CFG_W'(rand_count()));
            end
            idle_on = (n_sent < 200 || n_sent > 300);
            random_matrix();
        end
        idle_on = 1'b1;
        drain();
        repeat (200) @(posedge i_clk);
        if (expected_scales.size() != 0) begin
            $error("%0d expected result words never arrived", expected_scales.size());
            failed = 1'b1;
        end
        $display("Covered %0d loads and %0d reads over %0d scaling runs, %0d words checked,",
                 n_loads, n_reads, n_computes, n_checked);
        $display("with bad values, index and order errors, and counts from 0 to 2047.");
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(8 * 40_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/gms_pkg.sv
design/gms_if.sv
design/gms_log2.sv
design/geometric_matrix_scaling.sv
test/geometric_matrix_scaling_tb.sv
